/* rtl/pptcm_pkg.sv */
// Shared types, constants and helper functions of the pixel pair terminal colour mapper.
// Depends on nothing; every rtl module imports it.
package pptcm_pkg;

    // Render modes of the configuration register
    localparam logic [2:0] MODE_ASCII  = 3'd0;
    localparam logic [2:0] MODE_EIGHT  = 3'd1;
    localparam logic [2:0] MODE_GREY   = 3'd2;
    localparam logic [2:0] MODE_CUBE   = 3'd3;
    localparam logic [2:0] MODE_DIRECT = 3'd4;

    // Reciprocal multipliers: floor(s/3), floor(a*10/103), floor(t/46)
    localparam logic [19:0] AVG_RECIP   = 20'd683;   // shift 11, s <= 765
    localparam logic [20:0] GREY_RECIP  = 21'd6363;  // shift 16, a <= 255
    localparam logic [19:0] GLYPH_RECIP = 20'd1425;  // shift 16, t <= 510

    localparam logic [7:0] CUBE_BASE   = 8'd16;
    localparam logic [7:0] GREY_FIRST  = 8'd232;
    localparam logic [7:0] GREY_OFFSET = 8'd231;
    localparam logic [5:0] EIGHT_BASE  = 6'd40;
    localparam logic [7:0] DARK_LIMIT  = 8'd30;
    localparam logic [7:0] LIGHT_LIMIT = 8'd200;
    localparam logic [3:0] GLYPH_LAST  = 4'd11;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Stage 1: per-channel weighted distances, channel sums, cube levels
    typedef struct packed {
        logic [2:0]             mode;
        t_rgb                   top;
        t_rgb                   bot;
        logic [9:0]             top_sum;
        logic [9:0]             bot_sum;
        logic [2:0][2:0]        top_lvl;   // [0] red, [1] green, [2] blue
        logic [2:0][2:0]        bot_lvl;
        logic [7:0][2:0][15:0]  prod;      // [colour][channel]
        logic                   dark;
        logic                   light;
    } t_s1;

    // Stage 2: averages, cube indices, first round of the nearest search
    typedef struct packed {
        logic [2:0]             mode;
        t_rgb                   top;
        t_rgb                   bot;
        logic [7:0]             top_avg;
        logic [7:0]             bot_avg;
        logic [7:0]             top_cube;
        logic [7:0]             bot_cube;
        logic [3:0][17:0]       dsum;
        logic [3:0][2:0]        idx;
        logic                   dark;
        logic                   light;
    } t_s2;

    // Stage 3: grey and glyph products, nearest colour resolved
    typedef struct packed {
        logic [2:0]             mode;
        t_rgb                   top;
        t_rgb                   bot;
        logic [7:0]             top_cube;
        logic [7:0]             bot_cube;
        logic [20:0]            top_grey;
        logic [20:0]            bot_grey;
        logic [19:0]            glyph_prod;
        logic [2:0]             near;
        logic                   dark;
        logic                   light;
    } t_s3;

    // Fixed eight-colour palette
    function automatic t_rgb eight_rgb(input logic [2:0] c);
        t_rgb v;
        case (c)
            3'd0:    v = '{red: 8'h00, green: 8'h00, blue: 8'h00};
            3'd1:    v = '{red: 8'hd0, green: 8'h10, blue: 8'h10};
            3'd2:    v = '{red: 8'h10, green: 8'he0, blue: 8'h10};
            3'd3:    v = '{red: 8'hf7, green: 8'hf5, blue: 8'h3a};
            3'd4:    v = '{red: 8'h10, green: 8'h10, blue: 8'hf0};
            3'd5:    v = '{red: 8'hfb, green: 8'h3d, blue: 8'hf8};
            3'd6:    v = '{red: 8'h10, green: 8'hf0, blue: 8'hf0};
            default: v = '{red: 8'hf0, green: 8'hf0, blue: 8'hf0};
        endcase
        return v;
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Cube level floor(x*5/253): count of thresholds reached
    function automatic logic [2:0] cube_level(input logic [7:0] x);
        logic [10:0] y;
        logic [2:0]  lvl;
        y   = {1'b0, x, 2'b00} + {3'b000, x};
        lvl = 3'd0;
        for (int k = 1; k <= 5; k++) begin
            if (y >= 11'(253 * k)) begin
                lvl = lvl + 3'd1;
            end
        end
        return lvl;
    endfunction

    // Twelve-step luminance ramp
    function automatic logic [6:0] ramp_glyph(input logic [3:0] i);
        logic [6:0] g;
        case (i)
            4'd0:    g = 7'h20;  // space
            4'd1:    g = 7'h60;  // backtick
            4'd2:    g = 7'h2e;  // full stop
            4'd3:    g = 7'h2c;  // comma
            4'd4:    g = 7'h2d;  // hyphen
            4'd5:    g = 7'h3a;  // colon
            4'd6:    g = 7'h2b;  // plus
            4'd7:    g = 7'h2a;  // asterisk
            4'd8:    g = 7'h25;  // percent
            4'd9:    g = 7'h24;  // dollar
            default: g = 7'h23;  // hash
        endcase
        return g;
    endfunction

endpackage

/* rtl/pptcm_stage_front.sv */
// First pipeline stage: channel sums, cube levels, dark/light flags and the
// 24 weighted channel distances to the eight-colour palette. Uses pptcm_pkg.
module pptcm_stage_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_mode,
    input  pptcm_pkg::t_rgb      i_top,
    input  pptcm_pkg::t_rgb      i_bot,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pptcm_pkg::t_s1       o_data
);
    import pptcm_pkg::*;

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    // Load when empty or when the next stage takes the current item
    assign o_ready = !r_valid || i_ready;

    // Work out the stage contents for the incoming pair
    always_comb begin
        logic [2:0][7:0] tch;
        logic [2:0][7:0] bch;
        logic [2:0][7:0] pch;
        t_rgb            pal;
        tch = {i_top.blue, i_top.green, i_top.red};
        bch = {i_bot.blue, i_bot.green, i_bot.red};
        n_data.mode    = i_mode;
        n_data.top     = i_top;
        n_data.bot     = i_bot;
        n_data.top_sum = {2'b00, tch[0]} + {2'b00, tch[1]} + {2'b00, tch[2]};
        n_data.bot_sum = {2'b00, bch[0]} + {2'b00, bch[1]} + {2'b00, bch[2]};
        for (int ch = 0; ch < 3; ch++) begin
            n_data.top_lvl[2'(ch)] = cube_level(tch[2'(ch)]);
            n_data.bot_lvl[2'(ch)] = cube_level(bch[2'(ch)]);
        end
        for (int c = 0; c < 8; c++) begin
            pal = eight_rgb(3'(c));
            pch = {pal.blue, pal.green, pal.red};
            for (int ch = 0; ch < 3; ch++) begin
                n_data.prod[3'(c)][2'(ch)] =
                    16'(abs_diff(pch[2'(ch)], tch[2'(ch)])) * 16'(tch[2'(ch)]);
            end
        end
        n_data.dark  = (tch[0] < DARK_LIMIT) && (tch[1] < DARK_LIMIT)
                    && (tch[2] < DARK_LIMIT);
        n_data.light = (tch[0] > LIGHT_LIMIT) && (tch[1] > LIGHT_LIMIT)
                    && (tch[2] > LIGHT_LIMIT);
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the payload on a transfer
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pptcm_stage_mid.sv */
// Second pipeline stage: pixel averages, cube palette indices, distance sums
// and the first round of the nearest-colour search. Uses pptcm_pkg.
module pptcm_stage_mid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pptcm_pkg::t_s1       i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pptcm_pkg::t_s2       o_data
);
    import pptcm_pkg::*;

    logic r_valid;
    t_s2  r_data;
    t_s2  n_data;

    assign o_ready = !r_valid || i_ready;

    // Averages by reciprocal, cube indices, pairwise minimum (earlier wins ties)
    always_comb begin
        logic [19:0]      tp;
        logic [19:0]      bp;
        logic [7:0][17:0] d;
        tp = 20'(i_data.top_sum) * AVG_RECIP;
        bp = 20'(i_data.bot_sum) * AVG_RECIP;
        n_data.mode     = i_data.mode;
        n_data.top      = i_data.top;
        n_data.bot      = i_data.bot;
        n_data.top_avg  = tp[18:11];
        n_data.bot_avg  = bp[18:11];
        n_data.top_cube = CUBE_BASE + 8'(i_data.top_lvl[0]) * 8'd36
                        + 8'(i_data.top_lvl[1]) * 8'd6 + 8'(i_data.top_lvl[2]);
        n_data.bot_cube = CUBE_BASE + 8'(i_data.bot_lvl[0]) * 8'd36
                        + 8'(i_data.bot_lvl[1]) * 8'd6 + 8'(i_data.bot_lvl[2]);
        for (int c = 0; c < 8; c++) begin
            d[3'(c)] = 18'(i_data.prod[3'(c)][0]) + 18'(i_data.prod[3'(c)][1])
                     + 18'(i_data.prod[3'(c)][2]);
        end
        for (int j = 0; j < 4; j++) begin
            if (d[3'(2 * j + 1)] < d[3'(2 * j)]) begin
                n_data.dsum[2'(j)] = d[3'(2 * j + 1)];
                n_data.idx[2'(j)]  = 3'(2 * j + 1);
            end else begin
                n_data.dsum[2'(j)] = d[3'(2 * j)];
                n_data.idx[2'(j)]  = 3'(2 * j);
            end
        end
        n_data.dark  = i_data.dark;
        n_data.light = i_data.light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pptcm_stage_back.sv */
// Third pipeline stage: grey and glyph reciprocal products, and the last two
// rounds of the nearest-colour search. Uses pptcm_pkg.
module pptcm_stage_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pptcm_pkg::t_s2       i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output pptcm_pkg::t_s3       o_data
);
    import pptcm_pkg::*;

    logic r_valid;
    t_s3  r_data;
    t_s3  n_data;

    assign o_ready = !r_valid || i_ready;

    // Finish the minimum search; the right side wins only when strictly smaller
    always_comb begin
        logic [17:0] d_lo;
        logic [17:0] d_hi;
        logic [2:0]  i_lo;
        logic [2:0]  i_hi;
        logic [8:0]  lum;
        if (i_data.dsum[1] < i_data.dsum[0]) begin
            d_lo = i_data.dsum[1];
            i_lo = i_data.idx[1];
        end else begin
            d_lo = i_data.dsum[0];
            i_lo = i_data.idx[0];
        end
        if (i_data.dsum[3] < i_data.dsum[2]) begin
            d_hi = i_data.dsum[3];
            i_hi = i_data.idx[3];
        end else begin
            d_hi = i_data.dsum[2];
            i_hi = i_data.idx[2];
        end
        lum = {1'b0, i_data.top_avg} + {1'b0, i_data.bot_avg};
        n_data.mode       = i_data.mode;
        n_data.top        = i_data.top;
        n_data.bot        = i_data.bot;
        n_data.top_cube   = i_data.top_cube;
        n_data.bot_cube   = i_data.bot_cube;
        n_data.top_grey   = 21'(i_data.top_avg) * GREY_RECIP;
        n_data.bot_grey   = 21'(i_data.bot_avg) * GREY_RECIP;
        n_data.glyph_prod = 20'(lum) * GLYPH_RECIP;
        n_data.near       = (d_hi < d_lo) ? i_hi : i_lo;
        n_data.dark       = i_data.dark;
        n_data.light      = i_data.light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pptcm_stage_out.sv */
// Output stage: mode selection, grey code clamp, glyph lookup and the packed
// result register that drives the master stream. Uses pptcm_pkg.
module pptcm_stage_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  pptcm_pkg::t_s3       i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_data
);
    import pptcm_pkg::*;

    logic        r_valid;
    logic [63:0] r_data;
    logic [63:0] n_data;

    assign o_ready = !r_valid || i_ready;

    // Select codes by mode and pack the result
    always_comb begin
        logic [4:0]  t_step;
        logic [4:0]  b_step;
        logic [7:0]  t_code;
        logic [7:0]  b_code;
        logic [3:0]  gi;
        logic [2:0]  near;
        logic        has_fg;
        logic        has_bg;
        logic [23:0] fg;
        logic [23:0] bg;
        t_step = i_data.top_grey[20:16];
        b_step = i_data.bot_grey[20:16];
        t_code = (t_step == 5'd0) ? GREY_FIRST : GREY_OFFSET + 8'(t_step);
        b_code = (b_step == 5'd0) ? GREY_FIRST : GREY_OFFSET + 8'(b_step);
        gi     = (i_data.glyph_prod[19:16] > GLYPH_LAST) ? GLYPH_LAST
                                                          : i_data.glyph_prod[19:16];
        near   = i_data.dark ? 3'd0 : (i_data.light ? 3'd7 : i_data.near);
        case (i_data.mode)
            MODE_ASCII: begin
                has_fg = 1'b0;
                fg     = '0;
                has_bg = 1'b0;
                bg     = '0;
            end
            MODE_EIGHT: begin
                has_fg = 1'b0;
                fg     = '0;
                has_bg = 1'b1;
                bg     = 24'(EIGHT_BASE + 6'(near));
            end
            MODE_GREY: begin
                has_fg = 1'b1;
                fg     = 24'(b_code);
                has_bg = 1'b1;
                bg     = 24'(t_code);
            end
            MODE_CUBE: begin
                has_fg = 1'b1;
                fg     = 24'(i_data.top_cube);
                has_bg = 1'b1;
                bg     = 24'(i_data.bot_cube);
            end
            default: begin
                has_fg = 1'b1;
                fg     = {i_data.top.red, i_data.top.green, i_data.top.blue};
                has_bg = 1'b1;
                bg     = {i_data.bot.red, i_data.bot.green, i_data.bot.blue};
            end
        endcase
        n_data = {7'd0, ramp_glyph(gi), bg, has_bg, fg, has_fg};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/pixel_pair_terminal_color_mapper.sv */
// Pixel pair terminal colour mapper: top level with the mode register and
// four pipeline stages. Uses pptcm_pkg and the pptcm_stage_* modules.
//
// Usage:
//   The slave stream carries one vertical pixel pair per transfer; the
//   master stream returns one packed result per pair, in order. The
//   configuration channel writes the 3-bit render mode (reset value: direct
//   rgb); it is always ready and should be written only while the pipeline
//   is empty. Each pair keeps the mode that was set when it entered.
//   A pair accepted on the slave stream is captured in the front register
//   and then passes through the mid, back and output registers before
//   its result is presented on the master stream.
//   Throughput: one pair per clock while the master stream does not stall;
//   each stage holds one pair and the weighted distance multipliers sit in
//   the front stage.
//   Reset clears all stage valid flags and sets the mode to direct rgb.
//   When the receiver stalls, the output register holds its result and the
//   upstream stages keep filling until every stage is occupied; only then
//   does s_axis_tready fall. Nothing is dropped or repeated.
module pixel_pair_terminal_color_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // top_red, top_green, top_blue, bottom_red, bottom_green, bottom_blue
    input  logic [47:0] s_axis_tdata,
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // has_foreground, foreground_code[24], has_background, background_code[24],
    // glyph[7], zero padding[7]
    output logic [63:0] m_axis_tdata,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import pptcm_pkg::*;

    logic [2:0] r_mode;
    t_rgb       top_px;
    t_rgb       bot_px;
    logic       v1;
    logic       v2;
    logic       v3;
    logic       rdy2;
    logic       rdy3;
    logic       rdy4;
    t_s1        s1;
    t_s2        s2;
    t_s3        s3;

    // Hold the render mode
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DIRECT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Unpack the input transfer
    assign top_px = '{red: s_axis_tdata[7:0], green: s_axis_tdata[15:8],
                      blue: s_axis_tdata[23:16]};
    assign bot_px = '{red: s_axis_tdata[31:24], green: s_axis_tdata[39:32],
                      blue: s_axis_tdata[47:40]};

    pptcm_stage_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_mode  (r_mode),
        .i_top   (top_px),
        .i_bot   (bot_px),
        .o_valid (v1),
        .i_ready (rdy2),
        .o_data  (s1)
    );

    pptcm_stage_mid u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .o_ready (rdy2),
        .i_data  (s1),
        .o_valid (v2),
        .i_ready (rdy3),
        .o_data  (s2)
    );

    pptcm_stage_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .o_ready (rdy3),
        .i_data  (s2),
        .o_valid (v3),
        .i_ready (rdy4),
        .o_data  (s3)
    );

    pptcm_stage_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .o_ready (rdy4),
        .i_data  (s3),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

    // Input back-pressure only arises from a stalled result
    a_stall_from_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output side could accept");

    // Every mode with a foreground code also gives a background code
    a_fg_implies_bg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[25])
        else $error("foreground without background");

    // Background-only results are eight-colour codes 40..47
    a_eight_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[25])
        |-> (m_axis_tdata[49:29] == 21'd5))
        else $error("eight-colour code out of range");

    // No result straight after reset
    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
